// File: design/ptg_pkg.sv
`default_nettype none

package ptg_pkg;

  localparam int CountBits    = 48;
  localparam int NumCoresDef  = 8;
  localparam int NumStatesDef = 8;

  localparam int CoreW    = 3;
  localparam int StateW   = 3;
  localparam int FreqW    = 16;
  localparam int UsageW   = 16;
  localparam int PctW     = 7;
  localparam int PeriodW  = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // 1000 times the largest period still fits in this many bits.
  localparam int DivW  = 26;
  localparam int ProdW = 24;

  localparam logic [StateW-1:0]  StateRst   = 3'd2;
  localparam logic [PctW-1:0]    PctMax     = 7'd100;
  localparam logic [PeriodW-1:0] PeriodOne  = 16'd1;
  localparam logic [DivW-1:0]    UsPerMs    = 26'd1000;
  localparam logic [ProdW-1:0]   Hundred    = 24'd100;
  localparam logic [UsageW-1:0]  UsageMax   = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLICY  = 3'd0,
    CFG_UPPER   = 3'd1,
    CFG_LOWER   = 3'd2,
    CFG_PERIOD  = 3'd3,
    CFG_SLOWEST = 3'd4,
    CFG_FREQ_LO = 3'd5,
    CFG_FREQ_HI = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_DEC,
    ST_DONE
  } gov_state_e;

  typedef struct packed {
    logic [CoreW-1:0]     core_id;
    logic [CountBits-1:0] busy_count;
  } in_t;

  typedef struct packed {
    logic [CoreW-1:0]  core_out;
    logic [StateW-1:0] new_state;
    logic [UsageW-1:0] usage_mhz;
    logic              priming;
  } out_t;

  // Frequency of one P-state from the two packed table registers.
  function automatic logic [FreqW-1:0] freq_of(input logic [CfgDataW-1:0] lo_word,
                                               input logic [CfgDataW-1:0] hi_word,
                                               input logic [StateW-1:0]   st);
    logic [CfgDataW-1:0] word;
    word = st[2] ? hi_word : lo_word;
    return word[st[1:0]*FreqW +: FreqW];
  endfunction

endpackage

`default_nettype wire

// File: design/pstate_threshold_governor.sv
`default_nettype none
// Threshold P-state governor.
// Input channel (in_valid_i / in_stall_o) carries one busy-cycle counter
// sample for one core. Output channel (out_valid_o / out_stall_i) returns one
// request per in-range sample: the core, the P-state to force on it, the
// measured usage in MHz and a flag marking a core's first (priming) sample.
// Samples for a core index at or above NUM_CORES are dropped silently.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready and
// writes one register per handshake; write it only while the block is idle.
// A sample passes from acceptance through the load, divide, multiply and
// decide states to the output register: the usage quotient comes from a restoring
// divider that produces one quotient bit per cycle. A priming sample goes from
// the load state straight to the final state.
// The block accepts no new sample while one is in flight, but it does accept
// one while a finished request still waits in the output register.
// If the receiver stalls, the request holds in the output register and the
// next result waits in its final state until the register frees up.
// Reset clears the configuration to its defaults, marks every core unprimed
// and sets every core's P-state to 2.
module pstate_threshold_governor #(
  parameter int NUM_CORES  = ptg_pkg::NumCoresDef,
  parameter int NUM_STATES = ptg_pkg::NumStatesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  ptg_pkg::in_t                  in_data_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output ptg_pkg::out_t                 out_data_o,
  input  logic                          out_stall_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ptg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ptg_pkg::*;

  localparam int CoreIdxW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int CntW     = $clog2(CountBits);
  localparam logic [StateW-1:0] MaxState = StateW'(NUM_STATES - 1);
  localparam logic [CntW-1:0]   CntLast  = CntW'(CountBits - 1);

  // Configuration registers.
  logic                cfg_policy_q;
  logic [PctW-1:0]     cfg_upper_q;
  logic [PctW-1:0]     cfg_lower_q;
  logic [PeriodW-1:0]  cfg_period_q;
  logic [StateW-1:0]   cfg_slowest_q;
  logic [CfgDataW-1:0] cfg_freq_lo_q;
  logic [CfgDataW-1:0] cfg_freq_hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_policy_q  <= 1'b0;
      cfg_upper_q   <= 7'd70;
      cfg_lower_q   <= 7'd20;
      cfg_period_q  <= 16'd100;
      cfg_slowest_q <= 3'd7;
      cfg_freq_lo_q <= '0;
      cfg_freq_hi_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POLICY:  cfg_policy_q  <= cfg_data_i[0];
        CFG_UPPER:   cfg_upper_q   <= cfg_data_i[PctW-1:0];
        CFG_LOWER:   cfg_lower_q   <= cfg_data_i[PctW-1:0];
        CFG_PERIOD:  cfg_period_q  <= cfg_data_i[PeriodW-1:0];
        CFG_SLOWEST: cfg_slowest_q <= cfg_data_i[StateW-1:0];
        CFG_FREQ_LO: cfg_freq_lo_q <= cfg_data_i;
        CFG_FREQ_HI: cfg_freq_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer.
  gov_state_e state_q, state_d;
  logic       in_acc;
  logic       out_load;
  logic       out_valid_q;
  logic [CntW-1:0] cnt_q;
  logic       range_q;
  logic       primed_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!range_q) begin
          state_d = ST_IDLE;
        end else if (!primed_rd) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DEC;
      ST_DEC: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // Input capture and per-core storage.
  logic [CoreIdxW+2:0]   in_core_wide;
  logic [CoreIdxW-1:0]   in_idx;
  logic                  in_range;
  logic [CoreW-1:0]      core_q;
  logic [CoreIdxW+2:0]   core_wide;
  logic [CoreIdxW-1:0]   idx_q;
  logic [CountBits-1:0]  count_q;
  logic [CountBits-1:0]  prev_rd_q;
  logic [CountBits-1:0]  prev_mem [NUM_CORES];
  logic                  primed_q [NUM_CORES];
  logic [StateW-1:0]     core_state_q [NUM_CORES];

  assign in_core_wide = (CoreIdxW+3)'(in_data_i.core_id);
  assign in_idx       = in_core_wide[CoreIdxW-1:0];
  assign in_range     = (32'(in_data_i.core_id) < 32'(NUM_CORES));
  assign core_wide    = (CoreIdxW+3)'(core_q);
  assign idx_q        = core_wide[CoreIdxW-1:0];
  assign primed_rd    = primed_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= 1'b0;
    end else if (in_acc) begin
      range_q <= in_range;
    end
  end

  // Previous counts: written on every in-range sample, read when it arrives.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      core_q  <= in_data_i.core_id;
      count_q <= in_data_i.busy_count;
      if (in_range) begin
        prev_rd_q <= prev_mem[in_idx];
      end
    end
    if (state_q == ST_LOAD && range_q) begin
      prev_mem[idx_q] <= count_q;
    end
  end

  // Threshold operands, prepared when the sample is loaded.
  logic [PeriodW-1:0]   period_eff;
  logic [DivW-1:0]      divisor;
  logic [StateW-1:0]    slow;
  logic [StateW-1:0]    cur_state;
  logic [StateW-1:0]    s_eff;
  logic [StateW-1:0]    s_next;
  logic                 at_slow;
  logic [FreqW-1:0]     f_cur;
  logic [FreqW-1:0]     f_next;
  logic [FreqW-1:0]     gap;

  assign period_eff = (cfg_period_q == '0) ? PeriodOne : cfg_period_q;
  assign divisor    = DivW'(period_eff) * UsPerMs;
  assign slow       = (cfg_slowest_q > MaxState) ? MaxState : cfg_slowest_q;
  assign cur_state  = core_state_q[idx_q];
  assign s_eff      = (cur_state > slow) ? slow : cur_state;
  assign s_next     = s_eff + 3'd1;
  assign at_slow    = (s_eff == slow);
  assign f_cur      = freq_of(cfg_freq_lo_q, cfg_freq_hi_q, s_eff);
  assign f_next     = freq_of(cfg_freq_lo_q, cfg_freq_hi_q, s_next);

  // At the slowest state the raise threshold is a plain share of its own
  // frequency, which is the general formula with a zero lower neighbor.
  always_comb begin
    if (at_slow) begin
      gap = f_cur;
    end else if (f_cur > f_next) begin
      gap = f_cur - f_next;
    end else begin
      gap = '0;
    end
  end

  // Shared restoring divider: one quotient bit per cycle, dividend shifts out
  // of quo_q as quotient bits shift in.
  logic [DivW-1:0]      div_q;
  logic [DivW-1:0]      rem_q;
  logic [CountBits-1:0] quo_q;
  logic [DivW:0]        shifted;
  logic [DivW:0]        trial;

  assign shifted = {rem_q, quo_q[CountBits-1]};
  assign trial   = shifted - {1'b0, div_q};

  // Decision datapath.
  logic [StateW-1:0] s_q;
  logic [StateW-1:0] slow_q;
  logic              at_slow_q;
  logic [FreqW-1:0]  fn_q;
  logic [FreqW-1:0]  gap_q;
  logic [ProdW-1:0]  up_prod_q;
  logic [ProdW-1:0]  lo_prod_q;
  logic [UsageW-1:0] usage_q;
  logic [UsageW-1:0] usage_sat;
  logic [PctW-1:0]   up_eff;
  logic [UsageW-1:0] excess;
  logic [ProdW-1:0]  excess100;
  logic              raise_hit;
  logic              reduce_hit;
  logic [StateW-1:0] next_state;
  out_t              res_q;

  assign usage_sat = (|quo_q[CountBits-1:UsageW]) ? UsageMax : quo_q[UsageW-1:0];
  assign up_eff    = (cfg_upper_q > PctMax) ? PctMax : cfg_upper_q;

  // usage > fn + floor(P/100) holds exactly when 100*(usage - fn) > P, and
  // usage < fn + floor(Q/100) when usage < fn or Q >= 100*(usage - fn + 1).
  assign excess     = usage_q - fn_q;
  assign excess100  = ProdW'(excess) * Hundred;
  assign raise_hit  = (usage_q > fn_q) && (up_prod_q < excess100);
  assign reduce_hit = !at_slow_q && ((usage_q < fn_q) || (lo_prod_q >= excess100 + Hundred));

  always_comb begin
    next_state = s_q;
    if (raise_hit) begin
      if (cfg_policy_q) begin
        next_state = '0;
      end else if (s_q != '0) begin
        next_state = s_q - 3'd1;
      end
    end else if (reduce_hit) begin
      if (s_q < slow_q) begin
        next_state = s_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        div_q     <= divisor;
        rem_q     <= '0;
        quo_q     <= count_q - prev_rd_q;
        s_q       <= s_eff;
        slow_q    <= slow;
        at_slow_q <= at_slow;
        fn_q      <= at_slow ? '0 : f_next;
        gap_q     <= gap;
        res_q     <= '{core_out: core_q, new_state: cur_state, usage_mhz: '0, priming: 1'b1};
      end
      ST_DIV: begin
        if (trial[DivW]) begin
          rem_q <= shifted[DivW-1:0];
          quo_q <= {quo_q[CountBits-2:0], 1'b0};
        end else begin
          rem_q <= trial[DivW-1:0];
          quo_q <= {quo_q[CountBits-2:0], 1'b1};
        end
      end
      ST_MUL: begin
        usage_q   <= usage_sat;
        up_prod_q <= ProdW'(gap_q) * ProdW'(up_eff);
        lo_prod_q <= ProdW'(gap_q) * ProdW'(cfg_lower_q);
      end
      ST_DEC: begin
        res_q <= '{core_out: core_q, new_state: next_state, usage_mhz: usage_q, priming: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == ST_LOAD) begin
      cnt_q <= CntLast;
    end else if (state_q == ST_DIV) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CORES; i++) begin
        primed_q[i]     <= 1'b0;
        core_state_q[i] <= StateRst;
      end
    end else begin
      if (state_q == ST_LOAD && range_q) begin
        primed_q[idx_q] <= 1'b1;
      end
      if (state_q == ST_DEC) begin
        core_state_q[idx_q] <= next_state;
      end
    end
  end

  // Output register.
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: design/ptg_checker.sv
`default_nettype none

module ptg_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire ptg_pkg::out_t out_data_o
);
  import ptg_pkg::*;

  // A stalled request stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output request changed");

  // Once a sample is taken, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a sample is in flight");

  // A priming request never reports usage.
  a_prime_usage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.priming) |-> (out_data_o.usage_mhz == '0))
    else $error("priming request carries nonzero usage");

  // A new request only appears after the block was busy with a sample.
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output request appeared without a sample in flight");

endmodule

bind pstate_threshold_governor ptg_checker u_ptg_checker (.*);

`default_nettype wire

// File: tb/pstate_threshold_governor_tb.sv
`timescale 1ns / 1ps

module pstate_threshold_governor_tb;
  import ptg_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam logic [CfgDataW-1:0] KnownLo = {16'd1800, 16'd2200, 16'd2600, 16'd3000};
  localparam logic [CfgDataW-1:0] KnownHi = {16'd600, 16'd800, 16'd1000, 16'd1400};
  // Frequencies that rise toward the slow end of the low word, so the gaps among states 0 to 3 collapse to zero.
  localparam logic [CfgDataW-1:0] RisingLo = {16'd3000, 16'd2000, 16'd1000, 16'd500};

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  in_t                 in_data_i;
  logic                in_stall_o;
  logic                out_valid_o;
  out_t                out_data_o;
  logic                out_stall_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pstate_threshold_governor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Governor state and register copies kept by the testbench.
  logic [CountBits-1:0] last_count [NumCoresDef];
  logic                 primed_q   [NumCoresDef];
  logic [StateW-1:0]    pstate_q   [NumCoresDef];
  logic                 policy_jump;
  logic [PctW-1:0]      up_pct;
  logic [PctW-1:0]      lo_pct;
  logic [PeriodW-1:0]   period_ms;
  logic [StateW-1:0]    slowest_cfg;
  logic [CfgDataW-1:0]  freq_lo_w;
  logic [CfgDataW-1:0]  freq_hi_w;

  out_t        decisions_due [$];
  out_t        want;
  int          err_count = 0;
  int unsigned cycle_count = 0;
  int          rx_hold_cycles = 0;
  bit          sender_gaps_on = 1'b1;
  bit          receiver_stalls_on = 1'b1;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("pstate_threshold_governor_tb: errors");
      $finish;
    end
  end

  function automatic void reset_model();
    policy_jump   = 1'b0;
    up_pct        = 7'd70;
    lo_pct        = 7'd20;
    period_ms     = 16'd100;
    slowest_cfg   = 3'd7;
    freq_lo_w     = '0;
    freq_hi_w     = '0;
    for (int c = 0; c < NumCoresDef; c++) begin
      last_count[c] = '0;
      primed_q[c]   = 1'b0;
      pstate_q[c]   = StateRst;
    end
  endfunction

  function automatic logic [FreqW-1:0] freq_mhz(input int s);
    logic [2*CfgDataW-1:0] tbl;
    tbl = {freq_hi_w, freq_lo_w};
    return tbl[s*FreqW +: FreqW];
  endfunction

  function automatic longint unsigned divisor_now();
    longint unsigned per;
    per = (period_ms == '0) ? 1 : period_ms;
    return per * 1000;
  endfunction

  // Raise and reduce limits for a core in its current, clamped state.
  function automatic void gov_limits(input int c, output logic [StateW-1:0] eff,
                                     output logic [StateW-1:0] slow,
                                     output longint unsigned raise,
                                     output longint unsigned reduce);
    longint unsigned f_cur, f_next, gap, up;
    // Three bits cannot name a state past the last one, so the slowest
    // state never needs clamping here.
    slow  = slowest_cfg;
    eff   = (pstate_q[c] > slow) ? slow : pstate_q[c];
    up    = (up_pct > PctMax) ? 100 : up_pct;
    f_cur = freq_mhz(eff);
    if (eff == slow) begin
      raise  = f_cur * up / 100;
      reduce = 0;
    end else begin
      f_next = freq_mhz(eff + 1);
      gap    = (f_cur > f_next) ? f_cur - f_next : 0;
      raise  = f_next + gap * up / 100;
      reduce = f_next + gap * lo_pct / 100;
    end
  endfunction

  function automatic out_t predict_decision(input in_t req);
    out_t                 res;
    int                   c;
    logic [CountBits-1:0] delta;
    longint unsigned      usage, raise, reduce;
    logic [StateW-1:0]    eff, slow, nxt;
    c            = req.core_id;
    res.core_out = req.core_id;
    if (!primed_q[c]) begin
      last_count[c]  = req.busy_count;
      primed_q[c]    = 1'b1;
      res.new_state  = pstate_q[c];
      res.usage_mhz  = '0;
      res.priming    = 1'b1;
      return res;
    end
    delta = req.busy_count - last_count[c];
    usage = delta / divisor_now();
    last_count[c] = req.busy_count;
    gov_limits(c, eff, slow, raise, reduce);
    nxt = eff;
    if (usage > raise) begin
      if (policy_jump) nxt = '0;
      else if (eff != '0) nxt = eff - 1;
    end else if (usage < reduce) begin
      if (eff < slow) nxt = eff + 1;
    end
    pstate_q[c]   = nxt;
    res.new_state = nxt;
    res.usage_mhz = (usage > UsageMax) ? UsageMax : usage[UsageW-1:0];
    res.priming   = 1'b0;
    return res;
  endfunction

  function automatic logic [CountBits-1:0] rand_count();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[CountBits-1:0];
  endfunction

  // Counter value that makes the core read exactly the given usage.
  function automatic logic [CountBits-1:0] count_for_usage(input int c,
                                                           input longint unsigned target);
    longint unsigned      divisor;
    int unsigned          top;
    logic [CountBits-1:0] delta;
    divisor = divisor_now();
    top     = divisor - 1;
    delta   = target * divisor + $urandom_range(0, top);
    return last_count[c] + delta;
  endfunction

  // Mostly usages on and around the thresholds, some saturating, a few raw counts.
  function automatic logic [CountBits-1:0] next_count(input int c);
    logic [StateW-1:0] eff, slow;
    longint unsigned   raise, reduce, target;
    int unsigned       top;
    if ($urandom_range(0, 19) == 0) return rand_count();
    gov_limits(c, eff, slow, raise, reduce);
    top = raise + raise / 2 + 16;
    case ($urandom_range(0, 9))
      0: target = raise + 1;
      1: target = raise;
      2: target = (reduce > 0) ? reduce - 1 : 0;
      3: target = reduce;
      4: target = 0;
      5: target = 65536 + $urandom_range(0, 100000);
      default: target = $urandom_range(0, top);
    endcase
    return count_for_usage(c, target);
  endfunction

  function automatic logic [PctW-1:0] pick_pct();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd127;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  task automatic send_sample(input int core, input logic [CountBits-1:0] count);
    in_t req;
    req.core_id    = core;
    req.busy_count = count;
    if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    decisions_due.push_back(predict_decision(req));
  endtask

  // Stop offering samples until every pending decision has come back.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_POLICY:  policy_jump   = value[0];
      CFG_UPPER:   up_pct        = value[PctW-1:0];
      CFG_LOWER:   lo_pct        = value[PctW-1:0];
      CFG_PERIOD:  period_ms     = value[PeriodW-1:0];
      CFG_SLOWEST: slowest_cfg   = value[StateW-1:0];
      CFG_FREQ_LO: freq_lo_w     = value;
      CFG_FREQ_HI: freq_hi_w     = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_settings();
    logic [FreqW-1:0]   f [8];
    logic [PeriodW-1:0] per;
    int                 stride, mode, tmp;
    mode   = $urandom_range(0, 7);
    stride = ($urandom_range(0, 1) != 0) ? 600 : 9000;
    f[7]   = $urandom_range(50, 800);
    for (int s = 6; s >= 0; s--) begin
      tmp  = f[s+1] + $urandom_range(0, stride);
      f[s] = (tmp > 65535) ? 16'hFFFF : tmp;
    end
    if (mode == 6) begin
      for (int s = 0; s < 8; s++) f[s] = $urandom;
    end else if (mode == 7) begin
      f[0] = 16'hFFFF;
      f[7] = 16'h0000;
    end
    case ($urandom_range(0, 9))
      0: per = 16'd0;
      1: per = 16'd1;
      2: per = 16'hFFFF;
      3: per = $urandom;
      default: per = $urandom_range(1, 200);
    endcase
    write_reg(CFG_POLICY, $urandom_range(0, 1));
    write_reg(CFG_UPPER, pick_pct());
    write_reg(CFG_LOWER, pick_pct());
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_SLOWEST, ($urandom_range(0, 2) == 0) ? 7 : $urandom_range(0, 7));
    write_reg(CFG_FREQ_LO, {f[3], f[2], f[1], f[0]});
    write_reg(CFG_FREQ_HI, {f[7], f[6], f[5], f[4]});
  endtask

  // The first sample of each core only primes its counter.
  task automatic test_priming();
    for (int c = 0; c < NumCoresDef; c++) begin
      send_sample(c, (c == 0) ? '0 : (c == 1) ? '1 : rand_count());
    end
  endtask

  task automatic test_wrap_and_saturation();
    send_sample(0, count_for_usage(0, 1));
    // Core 1 last read all ones, so this delta wraps through zero.
    send_sample(1, count_for_usage(1, 3));
    send_sample(2, last_count[2] + 48'h8000_0000_0000);
  endtask

  task automatic test_step_policy();
    wait_quiet();
    write_reg(CFG_FREQ_LO, KnownLo);
    write_reg(CFG_FREQ_HI, KnownHi);
    write_reg(CFG_PERIOD, 16'd1);
    send_sample(3, count_for_usage(3, 2081));
    send_sample(4, count_for_usage(4, 1879));
    send_sample(3, count_for_usage(3, 2480));
    send_sample(5, count_for_usage(5, 0));
    send_sample(0, count_for_usage(0, 60000));
    send_sample(0, count_for_usage(0, 60000));
  endtask

  task automatic test_rocket_policy();
    wait_quiet();
    write_reg(CFG_POLICY, 1);
    send_sample(4, count_for_usage(4, 65000));
  endtask

  task automatic test_register_corners();
    wait_quiet();
    write_reg(CFG_POLICY, 0);
    write_reg(CFG_PERIOD, 16'd0);
    send_sample(6, count_for_usage(6, 2000));
    wait_quiet();
    write_reg(CFG_UPPER, 7'd127);
    send_sample(7, count_for_usage(7, 2200));
    send_sample(7, count_for_usage(7, 2201));
    wait_quiet();
    write_reg(CFG_UPPER, 7'd0);
    write_reg(CFG_LOWER, 7'd127);
    send_sample(6, count_for_usage(6, 1000));
    wait_quiet();
    // Cores sitting past the new slowest state get pulled back to it.
    write_reg(CFG_UPPER, 7'd100);
    write_reg(CFG_LOWER, 7'd0);
    write_reg(CFG_SLOWEST, 3'd1);
    send_sample(6, count_for_usage(6, 100));
    wait_quiet();
    write_reg(CFG_SLOWEST, 3'd0);
    send_sample(2, count_for_usage(2, 5));
    wait_quiet();
    write_reg(CFG_SLOWEST, 3'd7);
    write_reg(CFG_FREQ_LO, RisingLo);
    send_sample(5, count_for_usage(5, 100));
    send_sample(5, count_for_usage(5, 2500));
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    int c;
    wait_quiet();
    rx_hold_cycles = 300;
    repeat (12) begin
      c = $urandom_range(0, NumCoresDef - 1);
      send_sample(c, next_count(c));
    end
    wait_quiet();
  endtask

  task automatic test_random_phases();
    int c;
    for (int ph = 0; ph < 12; ph++) begin
      wait_quiet();
      if (ph >= 10) begin
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
      end
      random_settings();
      repeat (110) begin
        c = $urandom_range(0, NumCoresDef - 1);
        send_sample(c, next_count(c));
      end
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic flag_field(input string what, input longint unsigned want_v,
                            input longint unsigned got_v);
    if (want_v != got_v) begin
      $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      err_count++;
    end
  endtask

  // Decisions come back in request order, one per accepted sample.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decisions_due.size() == 0) begin
        $display("time %0t: unexpected decision, expected none, actual core %0d state %0d",
                 $time, out_data_o.core_out, out_data_o.new_state);
        err_count++;
      end else begin
        want = decisions_due.pop_front();
        flag_field("core_out", want.core_out, out_data_o.core_out);
        flag_field("new_state", want.new_state, out_data_o.new_state);
        flag_field("usage_mhz", want.usage_mhz, out_data_o.usage_mhz);
        flag_field("priming", want.priming, out_data_o.priming);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    reset_model();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_priming();
    test_wrap_and_saturation();
    test_step_policy();
    test_rocket_policy();
    test_register_corners();
    test_backpressure();
    test_random_phases();

    wait_quiet();
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && decisions_due.size() == 0) begin
      $display("pstate_threshold_governor_tb: clean");
    end else begin
      $display("pstate_threshold_governor_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ptg_pkg.sv
design/pstate_threshold_governor.sv
design/ptg_checker.sv
tb/pstate_threshold_governor_tb.sv
